>>> src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes for the sorted priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int ID_W    = 31;
  localparam int SCORE_W = 16;

  // one stored record
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
  } record_t;

  // request codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_INSERTED = 2'd0;
  localparam logic [1:0] STAT_REMOVED  = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_PIV,
    S_CMP,
    S_WRB
  } state_t;

endpackage

`default_nettype wire

>>> src/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded ring of (id, score) records kept in descending score order
// ----------------------------------------------------------------------------
// timing: full or empty answers are registered in the cycle after accept; a remove
//   answers from S_POP, an insert into a non-empty queue after its S_PIV, S_CMP, S_WRB passes
// throughput: one transaction at a time, busy stays high until the result;
//   the insert time is set by the single compare unit and memory write port
// results are strobed for one cycle on out_valid, the receiver cannot stall
// reset (rst_n low, synchronous) empties the queue; record memory is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // request side
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_mode,
  input  wire logic [ID_W-1:0]            in_rec_id,
  input  wire logic [SCORE_W-1:0]         in_rec_score,
  // result side
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [ID_W-1:0]                 out_id,
  output logic [SCORE_W-1:0]              out_score,
  output logic [$clog2(DEPTH+1)-1:0]      out_occupancy
);

  // slot index width and occupancy width
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_L = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // sequencer and queue state
  state_t          state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   i_r, i_nxt;      // logical position being settled
  logic [AW-1:0]   j_r, j_nxt;      // logical position being compared
  record_t         pivot_r, pivot_nxt;

  // result registers
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [ID_W-1:0] out_id_r, out_id_nxt;
  logic [SCORE_W-1:0] out_score_r, out_score_nxt;
  logic [CW-1:0]   out_occ_r, out_occ_nxt;

  // memory port
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  record_t         mem_wrec;
  logic [AW-1:0]   mem_raddr;
  record_t         mem_rrec;

  // count widened to compare against logical positions
  logic [AW:0]     count_l;

  // logical position to physical slot: the sum stays below twice the depth,
  // so one compare and subtract does the wrap
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [AW-1:0] logical);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, logical};
    if (sum >= DEPTH_L) begin
      sum = sum - DEPTH_L;
    end
    return sum[AW-1:0];
  endfunction

  spq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_rec  (mem_wrec),
    .rd_addr (mem_raddr),
    .rd_rec  (mem_rrec)
  );

  assign count_l = (AW+1)'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and loop counters need no reset
  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    pivot_r      <= pivot_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_score_r  <= out_score_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  // sequencer: the sort keeps the record of position i in the pivot register;
  // each compare against position j that finds a higher score writes the pivot to j
  // and takes the record of j, and the final pivot is written back to i
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    pivot_nxt      = pivot_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_score_nxt  = out_score_r;
    out_occ_nxt    = out_occ_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wrec       = pivot_r;
    mem_raddr      = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          out_id_nxt    = '0;
          out_score_nxt = '0;
          if (in_mode == MODE_INSERT) begin
            if (count_r == DEPTH_C) begin
              // full: drop the record
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_FULL;
              out_occ_nxt    = count_r;
            end else begin
              // append at the tail, start reading the head for the sort
              mem_we         = 1'b1;
              mem_waddr      = slot_of(head_r, count_r[AW-1:0]);
              mem_wrec.id    = in_rec_id;
              mem_wrec.score = in_rec_score;
              mem_raddr      = head_r;
              count_nxt      = count_r + CW'(1);
              i_nxt          = '0;
              if (count_r != '0) begin
                state_nxt = S_PIV;
              end else begin
                // single record, nothing to sort
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_INSERTED;
                out_occ_nxt    = count_r + CW'(1);
              end
            end
          end else begin
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_EMPTY;
              out_occ_nxt    = count_r;
            end else begin
              mem_raddr = head_r;
              state_nxt = S_POP;
            end
          end
        end
      end

      S_POP: begin
        // head record is on the read port now
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_REMOVED;
        out_id_nxt     = mem_rrec.id;
        out_score_nxt  = mem_rrec.score;
        out_occ_nxt    = count_r - CW'(1);
        head_nxt       = slot_of(head_r, AW'(1));
        count_nxt      = count_r - CW'(1);
        state_nxt      = S_IDLE;
      end

      S_PIV: begin
        // take position i as pivot, fetch position i+1
        pivot_nxt = mem_rrec;
        j_nxt     = i_r + AW'(1);
        mem_raddr = slot_of(head_r, i_r + AW'(1));
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if (pivot_r.score < mem_rrec.score) begin
          mem_we    = 1'b1;
          mem_waddr = slot_of(head_r, j_r);
          mem_wrec  = pivot_r;
          pivot_nxt = mem_rrec;
        end
        if (({1'b0, j_r} + (AW+1)'(1)) < count_l) begin
          j_nxt     = j_r + AW'(1);
          mem_raddr = slot_of(head_r, j_r + AW'(1));
        end else begin
          state_nxt = S_WRB;
        end
      end

      S_WRB: begin
        // settle position i, move on or finish
        mem_we    = 1'b1;
        mem_waddr = slot_of(head_r, i_r);
        mem_wrec  = pivot_r;
        if (({1'b0, i_r} + (AW+1)'(2)) < count_l) begin
          i_nxt     = i_r + AW'(1);
          mem_raddr = slot_of(head_r, i_r + AW'(1));
          state_nxt = S_PIV;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_INSERTED;
          out_id_nxt     = '0;
          out_score_nxt  = '0;
          out_occ_nxt    = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_id        = out_id_r;
  assign out_score     = out_score_r;
  assign out_occupancy = out_occ_r;

endmodule

`default_nettype wire

>>> src/spq_store.sv
// ----------------------------------------------------------------------------
// spq_store
// record memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module spq_store
  import spq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire record_t       wr_rec,
  input  wire logic [AW-1:0] rd_addr,
  output record_t            rd_rec
);

  record_t mem [DEPTH];
  record_t rd_rec_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    rd_rec_r <= mem[rd_addr];
  end

  assign rd_rec = rd_rec_r;

endmodule

`default_nettype wire
